// ===== hw/rtl/vkd_pkg.sv =====
// Shared types and constants for the vertex key deduplication table.
package vkd_pkg;

    // Table geometry
    localparam int ENTRIES  = 1024;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int COUNT_W  = $clog2(ENTRIES + 1);

    // Key layout: position, texture, normal
    localparam int KEY_PARTS = 3;
    localparam int FIELD_W   = 16;
    localparam int KEY_W     = KEY_PARTS * FIELD_W;

    // Reported slot width
    localparam int SLOT_W = 10;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef logic [KEY_W-1:0] vkd_key_t;

    typedef struct packed {
        logic [FIELD_W-1:0] position_index;
        logic [FIELD_W-1:0] texture_index;
        logic [FIELD_W-1:0] normal_index;
    } vkd_item_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              was_added;
        logic              table_full;
    } vkd_result_t;

    // Head of the queue as seen by the back end
    typedef struct packed {
        logic     valid;
        vkd_key_t key;
    } vkd_req_t;

endpackage

// ===== hw/rtl/vkd_front.sv =====
// Front end: takes items, packs them into keys and queues them for the scan.
module vkd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  vkd_pkg::vkd_item_t item,
    output logic              busy,
    output vkd_pkg::vkd_req_t  req,
    input  logic              pop
);

    vkd_pkg::vkd_key_t               queue_reg [vkd_pkg::QUEUE_DEPTH];
    logic [vkd_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [vkd_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [vkd_pkg::QPTR_W:0]        fill_reg;
    logic                            push;
    logic                            do_pop;
    vkd_pkg::vkd_key_t               key_in;

    // Pack as position:texture:normal
    assign key_in = {item.position_index, item.texture_index, item.normal_index};

    assign busy   = (fill_reg == (vkd_pkg::QPTR_W + 1)'(vkd_pkg::QUEUE_DEPTH));
    assign push   = start && !busy;
    assign do_pop = pop && (fill_reg != '0);

    assign req.valid = (fill_reg != '0);
    assign req.key   = queue_reg[rd_ptr_reg];

    // Queue pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !do_pop)
                fill_reg <= fill_reg + 1'b1;
            else if (do_pop && !push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            queue_reg[wr_ptr_reg] <= key_in;
    end

endmodule

// ===== hw/rtl/vkd_scan.sv =====
// Back end: key store, linear scan in insertion order, append on miss.
module vkd_scan (
    input  logic                clk,
    input  logic                rst_n,
    input  vkd_pkg::vkd_req_t    req,
    output logic                pop,
    output logic                done,
    output vkd_pkg::vkd_result_t result
);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t                         state_reg, state_next;
    logic [vkd_pkg::COUNT_W-1:0]    count_reg, count_next;
    logic [vkd_pkg::COUNT_W-1:0]    issue_idx_reg, issue_idx_next;
    logic                           cmp_valid_reg, cmp_valid_next;
    logic [vkd_pkg::IDX_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic                           done_reg, done_next;
    vkd_pkg::vkd_result_t           result_reg, result_next;
    vkd_pkg::vkd_key_t              key_reg, key_next;

    vkd_pkg::vkd_key_t              key_store [vkd_pkg::ENTRIES];
    vkd_pkg::vkd_key_t              rd_data_reg;
    logic                           rd_en;
    logic                           wr_en;
    logic                           hit;

    assign hit    = cmp_valid_reg && (rd_data_reg == key_reg);
    assign done   = done_reg;
    assign result = result_reg;

    // Sequencer: while scanning, one read issued per cycle, compared in the cycle after
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        issue_idx_next = issue_idx_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = issue_idx_reg[vkd_pkg::IDX_W-1:0];
        done_next      = 1'b0;
        result_next    = result_reg;
        key_next       = key_reg;
        pop            = 1'b0;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    pop            = 1'b1;
                    key_next       = req.key;
                    issue_idx_next = '0;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    result_next.slot       = vkd_pkg::SLOT_W'(cmp_idx_reg);
                    result_next.was_added  = 1'b0;
                    result_next.table_full = 1'b0;
                    done_next              = 1'b1;
                    state_next             = ST_IDLE;
                end
                else if (issue_idx_reg == count_reg)
                begin
                    // Every stored key compared, none matched
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                    if (count_reg == vkd_pkg::COUNT_W'(vkd_pkg::ENTRIES))
                    begin
                        result_next.slot       = '0;
                        result_next.was_added  = 1'b0;
                        result_next.table_full = 1'b1;
                    end
                    else
                    begin
                        wr_en                  = 1'b1;
                        count_next             = count_reg + 1'b1;
                        result_next.slot       = vkd_pkg::SLOT_W'(count_reg);
                        result_next.was_added  = 1'b1;
                        result_next.table_full = 1'b0;
                    end
                end
                else
                begin
                    rd_en          = 1'b1;
                    cmp_valid_next = 1'b1;
                    issue_idx_next = issue_idx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            issue_idx_reg <= '0;
            cmp_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_idx_reg <= issue_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            done_reg      <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        result_reg  <= result_next;
        key_reg     <= key_next;
    end

    // Key store: one write or one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            key_store[count_reg[vkd_pkg::IDX_W-1:0]] <= key_reg;
        if (rd_en)
            rd_data_reg <= key_store[issue_idx_reg[vkd_pkg::IDX_W-1:0]];
    end

endmodule

// ===== hw/rtl/vertex_key_dedup_table.sv =====
// Top level of the vertex key deduplication table.
//
// Each transfer on start/item is one face-corner key; each strobe on done
// carries one result, in input order, and must be taken that cycle since the
// receiver cannot stall. A two-entry input queue accepts keys while the scan
// runs; busy is high only when that queue is full. The scan reads one stored
// key per cycle from the single-port key store, so an item's time in the back
// end grows with N, the number of keys stored so far (up to 1024). The table
// is empty after reset and needs no clearing pass.
module vertex_key_dedup_table (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  vkd_pkg::vkd_item_t    item,
    output logic                 busy,
    output logic                 done,
    output vkd_pkg::vkd_result_t  result
);

    vkd_pkg::vkd_req_t req;
    logic              pop;

    vkd_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .item  (item),
        .busy  (busy),
        .req   (req),
        .pop   (pop)
    );

    vkd_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .pop    (pop),
        .done   (done),
        .result (result)
    );

    // A result is a hit, an append or a full-table miss, never two of these
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.was_added && result.table_full))
        else $error("result flags both added and full");

    // Full-table miss reports slot zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.table_full) |-> (result.slot == '0))
        else $error("full result with non-zero slot");

    // Each item passes through the idle state before its scan, so strobes never abut
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    // Nothing is popped from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> req.valid)
        else $error("pop from empty queue");

endmodule

// ===== dv/testbench.sv =====
// Testbench for vertex_key_dedup_table: random and directed keys, scoreboard check of results.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic                 clk    = 1'b0;
    logic                 rst_n  = 1'b0;
    logic                 start  = 1'b0;
    vkd_pkg::vkd_item_t   item   = '0;
    logic                 busy;
    logic                 done;
    vkd_pkg::vkd_result_t result;

    // Keys waiting to be driven, results waiting to arrive
    vkd_pkg::vkd_item_t   pending_items[$];
    vkd_pkg::vkd_result_t expected_results[$];
    int unsigned errors = 0;

    // Scoreboard copy of the table: slot of each stored key, and how many are stored
    int unsigned slot_by_key[vkd_pkg::vkd_key_t];
    int unsigned key_count = 0;

    // Stimulus side view of the table, used only to choose hits and misses
    vkd_pkg::vkd_key_t    planned_keys[$];
    bit                   planned_seen[vkd_pkg::vkd_key_t];

    // Sender burst and gap bookkeeping
    int unsigned burst_items = 0;
    int unsigned gap_cycles  = 0;

    vertex_key_dedup_table i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always #6 clk = ~clk;

    // Look the key up, append it if there is room, and return what the table should answer
    function automatic vkd_pkg::vkd_result_t dedup_lookup(vkd_pkg::vkd_item_t corner);
        vkd_pkg::vkd_key_t    k;
        vkd_pkg::vkd_result_t r;
        k = corner;
        r = '0;
        if (slot_by_key.exists(k)) begin
            r.slot = vkd_pkg::SLOT_W'(slot_by_key[k]);
        end
        else if (key_count < vkd_pkg::ENTRIES) begin
            slot_by_key[k] = key_count;
            r.slot         = vkd_pkg::SLOT_W'(key_count);
            r.was_added    = 1'b1;
            key_count++;
        end
        else begin
            r.table_full = 1'b1;
        end
        return r;
    endfunction

    // Index value: absent, all ones, small one-based, or anything
    function automatic logic [vkd_pkg::FIELD_W-1:0] pick_index();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return vkd_pkg::FIELD_W'($urandom_range(1, 64));
            default: return vkd_pkg::FIELD_W'($urandom);
        endcase
    endfunction

    function automatic vkd_pkg::vkd_key_t random_key();
        return {pick_index(), pick_index(), pick_index()};
    endfunction

    // A key not yet planned into the table
    function automatic vkd_pkg::vkd_key_t fresh_key();
        vkd_pkg::vkd_key_t k;
        do
            k = random_key();
        while (planned_seen.exists(k));
        return k;
    endfunction

    function automatic vkd_pkg::vkd_key_t stored_key();
        return planned_keys[$urandom_range(0, planned_keys.size() - 1)];
    endfunction

    // Queue a key for driving and track what the table will hold
    function automatic void push_key(vkd_pkg::vkd_key_t k);
        pending_items = {pending_items, vkd_pkg::vkd_item_t'(k)};
        if (!planned_seen.exists(k) && planned_keys.size() < vkd_pkg::ENTRIES) begin
            planned_seen[k] = 1'b1;
            planned_keys    = {planned_keys, k};
        end
    endfunction

    // Driver: present the next key, in bursts with gaps between them
    always @(posedge clk) begin
        if (!rst_n) begin
            start <= 1'b0;
        end
        else if (!start || !busy) begin
            if (gap_cycles > 0) begin
                gap_cycles--;
                start <= 1'b0;
            end
            else if (pending_items.size() > 0) begin
                item  <= pending_items.pop_front();
                start <= 1'b1;
                if (burst_items > 0) begin
                    burst_items--;
                end
                else begin
                    burst_items = $urandom_range(0, 15);
                    case ($urandom_range(0, 7))
                        0, 1, 2: gap_cycles = 0;
                        7:       gap_cycles = $urandom_range(100, 1200);
                        default: gap_cycles = $urandom_range(1, 10);
                    endcase
                end
            end
            else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: check each strobed result, then predict for a transfer taken at this edge
    always @(posedge clk) begin : monitor
        vkd_pkg::vkd_result_t want;
        if (rst_n) begin
            if (done) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with none expected: slot %0d added %0b full %0b",
                             $time, result.slot, result.was_added, result.table_full);
                    errors++;
                end
                else begin
                    want = expected_results.pop_front();
                    if (result.slot !== want.slot) begin
                        $display("%0t: slot mismatch: expected %0d, got %0d",
                                 $time, want.slot, result.slot);
                        errors++;
                    end
                    if (result.was_added !== want.was_added) begin
                        $display("%0t: was_added mismatch: expected %0b, got %0b",
                                 $time, want.was_added, result.was_added);
                        errors++;
                    end
                    if (result.table_full !== want.table_full) begin
                        $display("%0t: table_full mismatch: expected %0b, got %0b",
                                 $time, want.table_full, result.table_full);
                        errors++;
                    end
                end
            end
            if (start && !busy)
                expected_results = {expected_results, dedup_lookup(item)};
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int unsigned pick;
        int unsigned span;

        // Directed: extremes, single-field differences, repeats
        push_key({16'h0000, 16'h0000, 16'h0000});
        push_key({16'hFFFF, 16'hFFFF, 16'hFFFF});
        push_key({16'h0000, 16'h0000, 16'h0000});
        push_key({16'hFFFF, 16'h0000, 16'h0000});
        push_key({16'h0000, 16'hFFFF, 16'h0000});
        push_key({16'h0000, 16'h0000, 16'hFFFF});
        push_key({16'h0001, 16'h0001, 16'h0001});
        push_key({16'h0001, 16'h0001, 16'h0002});
        push_key({16'h0001, 16'h0002, 16'h0001});
        push_key({16'h0002, 16'h0001, 16'h0001});
        push_key({16'hAAAA, 16'h5555, 16'hAAAA});
        push_key({16'h5555, 16'hAAAA, 16'h5555});
        push_key({16'h0001, 16'h0001, 16'h0001});
        push_key({16'hFFFF, 16'hFFFF, 16'hFFFF});
        push_key({16'h0000, 16'hFFFF, 16'h0000});
        push_key({16'h5555, 16'hAAAA, 16'h5555});

        // Random: mesh-like traffic, corners often revisited soon after first use
        repeat (564) begin
            pick = $urandom_range(0, 19);
            span = (planned_keys.size() > 16) ? 15 : planned_keys.size() - 1;
            if (pick < 9)
                push_key(fresh_key());
            else if (pick < 16)
                push_key(planned_keys[planned_keys.size() - 1 - $urandom_range(0, span)]);
            else if (pick < 18)
                push_key(stored_key());
            else
                push_key(random_key());
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait until every transfer is taken and every result has come back
        while (pending_items.size() != 0 || start)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (1100) @(posedge clk);

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog
    initial begin
        #80_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/vkd_pkg.sv
hw/rtl/vkd_front.sv
hw/rtl/vkd_scan.sv
hw/rtl/vertex_key_dedup_table.sv
dv/testbench.sv
